/* src/wmf_pkg.sv */
// ----------------------------------------------------------------------------
// wmf_pkg
// Shared widths, register indexes, mode codes and the configuration bundle
// handed from the top level to each window stage.
// ----------------------------------------------------------------------------
package wmf_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_RADIUS = 3;
  localparam int MAX_HEIGHT     = 1024;

  localparam int PW   = 8;   // pixel width
  localparam int XW   = 11;  // column and register width
  localparam int YW   = 12;  // row counter, covers rows past the frame end
  localparam int RW   = 3;   // radius width
  localparam int DW   = 14;  // window delay in items
  localparam int TW   = 22;  // pixels per frame
  localparam int CW   = 23;  // linear item counters
  localparam int IDXW = 2;

  localparam logic [1:0] MODE_ERODE  = 2'd0;
  localparam logic [1:0] MODE_DILATE = 2'd1;
  localparam logic [1:0] MODE_OPEN   = 2'd2;
  localparam logic [1:0] MODE_CLOSE  = 2'd3;

  localparam logic [IDXW-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [IDXW-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [IDXW-1:0] REG_KERNEL_SIZE  = 2'd2;
  localparam logic [IDXW-1:0] REG_MORPH_MODE   = 2'd3;

  typedef struct packed {
    logic          restart;
    logic [XW-1:0] w;
    logic [XW-1:0] h;
    logic [RW-1:0] r;
    logic [DW-1:0] d;
    logic [TW-1:0] total;
  } wmf_cfg_t;

endpackage

/* src/wmf_ram.sv */
// ----------------------------------------------------------------------------
// wmf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module wmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rd_data_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem_r[raddr];
    end
  end

endmodule

/* src/wmf_stage.sv */
// ----------------------------------------------------------------------------
// wmf_stage
// One min/max window stage. A line RAM addressed by column holds the last
// 2*MAX_RADIUS rows; each item reads its column, reduces it vertically and
// writes the shifted column back. A short shift line of column results then
// gives the horizontal reduce. Items past the frame end are generated here.
// ----------------------------------------------------------------------------
module wmf_stage import wmf_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  wmf_cfg_t      cfg,
  input  logic          take_max,
  input  logic          ev_pix_valid,
  input  logic [PW-1:0] ev_pix,
  input  logic          prom_inc,
  output logic          res_valid,
  output logic [PW-1:0] res_pix,
  output logic          res_last
);

  localparam int TAPS = 2 * MAX_RADIUS + 1;
  localparam int LW   = PW * 2 * MAX_RADIUS;
  localparam int AW   = $clog2(MAX_WIDTH);

  // position counters
  logic [XW-1:0] x_r, x_nxt, xc_r, xc_nxt;
  logic [YW-1:0] y_r, y_nxt;
  logic [CW-1:0] p_r, p_nxt, mc_r, mc_nxt, prom_r, prom_nxt;
  logic          ev, emit, fin;

  // pipeline
  logic          s1_v_r, s2_v_r, res_v_r, fwd_r;
  logic [PW-1:0] s1_pix_r;
  logic [XW-1:0] s1_x_r, s1_xc_r, s2_x_r, s2_xc_r;
  logic [YW-1:0] s1_y_r;
  logic          s1_emit_r, s1_last_r, s2_emit_r, s2_last_r, res_last_r;
  logic [LW-1:0] fwd_d_r, rd_data, col, wb;
  logic [PW-1:0] s2_c_r, res_pix_r, vred, hred;
  logic [PW-1:0] hc_r [TAPS-1];
  logic [XW-1:0] hx_r [TAPS-1];

  always_comb begin
    ev   = adv && (ev_pix_valid || (p_r >= CW'(cfg.total) && mc_r < prom_r));
    emit = ev && (p_r >= CW'(cfg.d));
    fin  = emit && ((mc_r + CW'(1)) == CW'(cfg.total));

    x_nxt    = x_r;
    y_nxt    = y_r;
    p_nxt    = p_r;
    mc_nxt   = mc_r;
    xc_nxt   = xc_r;
    prom_nxt = prom_r;
    if (ev) begin
      if ((x_r + XW'(1)) == cfg.w) begin
        x_nxt = '0;
        y_nxt = y_r + YW'(1);
      end else begin
        x_nxt = x_r + XW'(1);
      end
      p_nxt = p_r + CW'(1);
    end
    if (emit) begin
      mc_nxt = mc_r + CW'(1);
      xc_nxt = ((xc_r + XW'(1)) == cfg.w) ? '0 : xc_r + XW'(1);
    end
    if (prom_inc) begin
      prom_nxt = prom_r + CW'(1);
    end
    if (cfg.restart || fin) begin
      x_nxt    = '0;
      y_nxt    = '0;
      p_nxt    = '0;
      mc_nxt   = '0;
      xc_nxt   = '0;
      prom_nxt = '0;
    end
  end

  wmf_ram #(
    .WIDTH(LW),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk      (clk),
    .we       (adv && s1_v_r),
    .waddr    (AW'(s1_x_r)),
    .wdata    (wb),
    .re       (ev),
    .raddr    (AW'(x_r)),
    .rd_data_r(rd_data)
  );

  // The previous item wrote the same column in the cycle this one was read.
  always_comb begin
    col = fwd_r ? fwd_d_r : rd_data;
    wb  = {col[LW-PW-1:0], s1_pix_r};
  end

  // Vertical reduce: tap k is row y-k; rows outside the frame are skipped.
  always_comb begin
    logic [PW-1:0] v;
    vred = take_max ? '0 : '1;
    for (int k = 0; k < TAPS; k++) begin
      v = (k == 0) ? s1_pix_r : col[PW*((k == 0) ? 0 : k-1) +: PW];
      if (((RW+1)'(k) <= {cfg.r, 1'b0}) && (s1_y_r >= YW'(k)) &&
          ((s1_y_r - YW'(k)) < YW'(cfg.h))) begin
        if (take_max ? (v > vred) : (v < vred)) begin
          vred = v;
        end
      end
    end
  end

  // Horizontal reduce: entry j belongs to the window when its column plus j
  // equals the center column plus the radius, which rules out wrapped rows.
  always_comb begin
    logic [PW-1:0] v;
    logic [XW-1:0] tx;
    hred = take_max ? '0 : '1;
    for (int j = 0; j < TAPS; j++) begin
      v  = (j == 0) ? s2_c_r : hc_r[(j == 0) ? 0 : j-1];
      tx = (j == 0) ? s2_x_r : hx_r[(j == 0) ? 0 : j-1];
      if (((RW+1)'(j) <= {cfg.r, 1'b0}) &&
          (({1'b0, tx} + (XW+1)'(j)) == ({1'b0, s2_xc_r} + (XW+1)'(cfg.r)))) begin
        if (take_max ? (v > hred) : (v < hred)) begin
          hred = v;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r     <= '0;
      y_r     <= '0;
      p_r     <= '0;
      mc_r    <= '0;
      xc_r    <= '0;
      prom_r  <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      res_v_r <= 1'b0;
      fwd_r   <= 1'b0;
    end else begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      p_r    <= p_nxt;
      mc_r   <= mc_nxt;
      xc_r   <= xc_nxt;
      prom_r <= prom_nxt;
      if (adv) begin
        s1_v_r  <= ev;
        fwd_r   <= ev && s1_v_r && (s1_x_r == x_r);
        s2_v_r  <= s1_v_r;
        res_v_r <= s2_v_r && s2_emit_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pix_r   <= ev_pix_valid ? ev_pix : '0;
      s1_x_r     <= x_r;
      s1_y_r     <= y_r;
      s1_emit_r  <= emit;
      s1_xc_r    <= xc_r;
      s1_last_r  <= fin;
      fwd_d_r    <= wb;
      s2_c_r     <= vred;
      s2_x_r     <= s1_x_r;
      s2_emit_r  <= s1_emit_r;
      s2_xc_r    <= s1_xc_r;
      s2_last_r  <= s1_last_r;
      res_pix_r  <= hred;
      res_last_r <= s2_last_r;
      if (s2_v_r) begin
        hc_r[0] <= s2_c_r;
        hx_r[0] <= s2_x_r;
        for (int j = 1; j < TAPS-1; j++) begin
          hc_r[j] <= hc_r[j-1];
          hx_r[j] <= hx_r[j-1];
        end
      end
    end
  end

  assign res_valid = res_v_r;
  assign res_pix   = res_pix_r;
  assign res_last  = res_last_r;

endmodule

/* src/window_morphology_filter.sv */
// ----------------------------------------------------------------------------
// window_morphology_filter
// Streaming erode, dilate, open and close over a square window of 8-bit
// pixels in raster order, built from one or two line-RAM window stages.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while input is not stalled by out_stall or
//   by the hold at a frame's end; the line RAM of each stage is read and
//   written once per item, with forwarding when one column repeats.
// Path: a result passes a stage's s1, s2 and result registers (both stages
//   for open and close) before the output register; a stage releases
//   center m once r*w+r later items have passed it. Input is held from the
//   item that releases the frame's last result until that result reaches
//   the output register.
// Reset: synchronous, active low; counters clear, registers take their
//   defaults; the line RAMs are not cleared.
module window_morphology_filter import wmf_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [PW-1:0]   in_pixel_in,
  input  logic            in_drain,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [PW-1:0]   out_pixel_out,
  output logic            out_frame_last,
  input  logic            cfg_we,
  input  logic [IDXW-1:0] cfg_index,
  input  logic [XW-1:0]   cfg_data
);

  localparam logic [XW:0] MaxW = (XW+1)'(MAX_WIDTH > 2047 ? 2047 : MAX_WIDTH);

  logic [XW-1:0] image_width_r, image_height_r;
  logic [2:0]    kernel_size_r;
  logic [1:0]    morph_mode_r;

  logic [XW-1:0] w_eff, h_eff;
  logic [RW-1:0] r_eff, r_half;
  logic [DW-1:0] d_eff;
  logic [TW-1:0] total_eff;
  wmf_cfg_t      scfg;
  logic          two, first_max;

  logic [CW-1:0] trk_in_r, trk_in_nxt, trk_mid_r, trk_mid_nxt, trk_out_r, trk_out_nxt;
  logic [CW-1:0] total_c, d_c, in_n, mid_n, src_n;
  logic          acc, adv, pix, skip, mid_e, emit, last;
  logic          fin_r, fin_nxt;

  logic          s1_v, s1_last, s2_v, s2_last, f_v, f_last;
  logic [PW-1:0] s1_pix, s2_pix, f_pix;
  logic          out_valid_r, out_last_r;
  logic [PW-1:0] out_pix_r;

  always_comb begin
    if (image_width_r == '0) begin
      w_eff = XW'(1);
    end else if ({1'b0, image_width_r} > MaxW) begin
      w_eff = MaxW[XW-1:0];
    end else begin
      w_eff = image_width_r;
    end
    if (image_height_r == '0) begin
      h_eff = XW'(1);
    end else if (image_height_r > XW'(MAX_HEIGHT)) begin
      h_eff = XW'(MAX_HEIGHT);
    end else begin
      h_eff = image_height_r;
    end
    r_half = (kernel_size_r == '0) ? '0 : RW'((kernel_size_r - 3'd1) >> 1);
    r_eff  = (r_half > RW'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : r_half;
    d_eff     = DW'(r_eff) * DW'(w_eff) + DW'(r_eff);
    total_eff = TW'(w_eff) * TW'(h_eff);
    two       = morph_mode_r inside {MODE_OPEN, MODE_CLOSE};
    first_max = morph_mode_r inside {MODE_DILATE, MODE_CLOSE};
    scfg.restart = cfg_we;
    scfg.w       = w_eff;
    scfg.h       = h_eff;
    scfg.r       = r_eff;
    scfg.d       = d_eff;
    scfg.total   = total_eff;
  end

  // The whole datapath moves together whenever the output register can load.
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv || fin_r;
  assign acc      = in_valid && !in_stall;

  // Frame bookkeeping at item level: decides which items owe a result.
  always_comb begin
    total_c = CW'(total_eff);
    d_c     = CW'(d_eff);
    pix     = !in_drain && (trk_in_r < total_c);
    skip    = in_drain && (trk_in_r < total_c);
    in_n    = trk_in_r + CW'(pix);
    mid_e   = two && !skip && (trk_mid_r < total_c) &&
              ((in_n >= total_c) || (in_n > trk_mid_r + d_c));
    mid_n   = trk_mid_r + CW'(mid_e);
    src_n   = two ? mid_n : in_n;
    emit    = !skip && (trk_out_r < total_c) &&
              ((src_n >= total_c) || (src_n > trk_out_r + d_c));
    last    = emit && ((trk_out_r + CW'(1)) == total_c);

    trk_in_nxt  = trk_in_r;
    trk_mid_nxt = trk_mid_r;
    trk_out_nxt = trk_out_r;
    fin_nxt     = fin_r;
    if (adv && f_v && f_last) begin
      fin_nxt = 1'b0;
    end
    if (acc) begin
      if (last) begin
        trk_in_nxt  = '0;
        trk_mid_nxt = '0;
        trk_out_nxt = '0;
        fin_nxt     = 1'b1;
      end else begin
        trk_in_nxt  = in_n;
        trk_mid_nxt = mid_n;
        trk_out_nxt = trk_out_r + CW'(emit);
      end
    end
    if (cfg_we) begin
      trk_in_nxt  = '0;
      trk_mid_nxt = '0;
      trk_out_nxt = '0;
    end
  end

  wmf_stage #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_RADIUS(MAX_RADIUS)
  ) u_stage1 (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .cfg         (scfg),
    .take_max    (first_max),
    .ev_pix_valid(acc && pix),
    .ev_pix      (in_pixel_in),
    .prom_inc    (acc && (two ? mid_e : emit)),
    .res_valid   (s1_v),
    .res_pix     (s1_pix),
    .res_last    (s1_last)
  );

  wmf_stage #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_RADIUS(MAX_RADIUS)
  ) u_stage2 (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .cfg         (scfg),
    .take_max    (!first_max),
    .ev_pix_valid(two && s1_v),
    .ev_pix      (s1_pix),
    .prom_inc    (acc && two && emit),
    .res_valid   (s2_v),
    .res_pix     (s2_pix),
    .res_last    (s2_last)
  );

  assign f_v    = two ? s2_v : s1_v;
  assign f_pix  = two ? s2_pix : s1_pix;
  assign f_last = two ? s2_last : s1_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= XW'(1024);
      image_height_r <= XW'(1024);
      kernel_size_r  <= 3'd3;
      morph_mode_r   <= MODE_ERODE;
      trk_in_r       <= '0;
      trk_mid_r      <= '0;
      trk_out_r      <= '0;
      fin_r          <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  image_width_r  <= cfg_data;
          REG_IMAGE_HEIGHT: image_height_r <= cfg_data;
          REG_KERNEL_SIZE:  kernel_size_r  <= cfg_data[2:0];
          REG_MORPH_MODE:   morph_mode_r   <= cfg_data[1:0];
          default: ;
        endcase
      end
      trk_in_r  <= trk_in_nxt;
      trk_mid_r <= trk_mid_nxt;
      trk_out_r <= trk_out_nxt;
      fin_r     <= fin_nxt;
      if (adv) begin
        out_valid_r <= f_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && f_v) begin
      out_pix_r  <= f_pix;
      out_last_r <= f_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_out  = out_pix_r;
  assign out_frame_last = out_last_r;

  a_fin_restarted: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r |-> (trk_in_r == '0 && trk_out_r == '0))
    else $error("frame counters not cleared while the last result drains");

  a_out_after_mid: assert property (@(posedge clk) disable iff (!rst_n)
    two |-> (trk_out_r <= trk_mid_r))
    else $error("second stage ahead of first stage");

  a_in_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    trk_in_r <= CW'(total_eff))
    else $error("input count beyond frame size");

endmodule
